/* src/ase_pkg.sv */
// Shared constants for the array store engine: operation and status codes, defaults.
// No dependencies; array_store_engine.sv in src imports this package (ase_ram.sv does not).
package ase_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int FUNC_W       = 4;
    localparam int POS_W        = 5;
    localparam int STATUS_W     = 3;

    localparam logic [FUNC_W-1:0] FN_APPEND    = 4'd0;
    localparam logic [FUNC_W-1:0] FN_INS_FRONT = 4'd1;
    localparam logic [FUNC_W-1:0] FN_INS_AT    = 4'd2;
    localparam logic [FUNC_W-1:0] FN_DEL_END   = 4'd3;
    localparam logic [FUNC_W-1:0] FN_DEL_AT    = 4'd4;
    localparam logic [FUNC_W-1:0] FN_UPDATE    = 4'd5;
    localparam logic [FUNC_W-1:0] FN_LSEARCH   = 4'd6;
    localparam logic [FUNC_W-1:0] FN_BSEARCH   = 4'd7;
    localparam logic [FUNC_W-1:0] FN_SORT      = 4'd8;
    localparam logic [FUNC_W-1:0] FN_READ      = 4'd9;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADPOS    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOTSORTED = 3'd5;

endpackage

/* src/array_store_engine.sv */
// Array store engine: a bounded array of signed 32-bit words kept in one RAM
// (one write and one read port, registered read data) plus an element count.
// One request is worked on at a time; each gives one result word. Every entry
// touched is read, then compared or written back. Insert and delete shift
// entries one at a time, linear search and update scan the entries, binary
// search checks the whole order before it probes, and sort runs bubble passes.
// A new request is taken while the previous result still waits on m_ready.
// Depends on ase_pkg and ase_ram.
module array_store_engine #(
    parameter int CAPACITY = ase_pkg::CAPACITY_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [ase_pkg::FUNC_W-1:0]           s_func,
    input  logic [ase_pkg::POS_W-1:0]            s_position,
    input  logic signed [ase_pkg::DATA_W-1:0]    s_value,
    input  logic signed [ase_pkg::DATA_W-1:0]    s_new_value,
    input  logic                                 s_replace_all,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [ase_pkg::STATUS_W-1:0]         m_status,
    output logic [ase_pkg::POS_W-1:0]            m_found_position,
    output logic signed [ase_pkg::DATA_W-1:0]    m_read_value,
    output logic [ase_pkg::POS_W-1:0]            m_count_now
);
    import ase_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int BW = CW + 1;
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [3:0] {
        S_IDLE, S_UP_RD, S_UP_WR, S_DN_RD, S_DN_WR, S_SCAN_RD, S_SCAN_WR,
        S_ASC_RD, S_ASC_WR, S_BIS_RD, S_BIS_WR, S_SORT_RD, S_SORT_WR,
        S_SORT_END, S_READ_WR, S_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           idx_reg, idx_next;
    logic [CW-1:0]           kidx_reg, kidx_next;
    logic [CW-1:0]           n_reg, n_next;
    logic [CW-1:0]           found_reg, found_next;
    logic [FUNC_W-1:0]       func_reg, func_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic signed [DATA_W-1:0] nval_reg, nval_next;
    logic                    all_reg, all_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [DATA_W-1:0]       rdv_reg, rdv_next;
    logic signed [DATA_W-1:0] data_reg, data_next;
    logic signed [BW-1:0]    lo_reg, lo_next;
    logic signed [BW-1:0]    hi_reg, hi_next;
    logic [AW-1:0]           mid_reg, mid_next;

    logic                    m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]     m_status_reg, m_status_next;
    logic [POS_W-1:0]        m_found_reg, m_found_next;
    logic [DATA_W-1:0]       m_rdv_reg, m_rdv_next;
    logic [POS_W-1:0]        m_count_reg, m_count_next;

    logic                    we;
    logic [AW-1:0]           waddr, raddr;
    logic [DATA_W-1:0]       wdata, rdata;

    logic [XW-1:0]           pos_x, cnt_x, fnd_x;
    logic                    pos_ok, is_full, is_empty, match, key_less;
    logic [BW:0]             bis_sum;
    logic [BW-1:0]           mid_w;
    logic [CW-1:0]           idx_m1, idx_p1;

    ase_ram #(
        .WIDTH(DATA_W),
        .DEPTH(CAPACITY)
    ) u_store (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign pos_x    = XW'(s_position);
    assign cnt_x    = XW'(count_next);
    assign fnd_x    = XW'(found_next);
    assign pos_ok   = (pos_x >= XW'(1)) && (pos_x <= XW'(count_reg));
    assign is_full  = count_reg >= CW'(CAPACITY);
    assign is_empty = count_reg == '0;
    assign match    = rdata == val_reg;
    assign key_less = val_reg < $signed(rdata);
    assign bis_sum  = {lo_reg[BW-1], lo_reg} + {hi_reg[BW-1], hi_reg};
    assign mid_w    = bis_sum[BW:1];
    assign idx_m1   = idx_reg - CW'(1);
    assign idx_p1   = idx_reg + CW'(1);

    assign s_ready          = state_reg == S_IDLE;
    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_found_position = m_found_reg;
    assign m_read_value     = m_rdv_reg;
    assign m_count_now      = m_count_reg;

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        kidx_next   = kidx_reg;
        n_next      = n_reg;
        found_next  = found_reg;
        func_next   = func_reg;
        val_next    = val_reg;
        nval_next   = nval_reg;
        all_next    = all_reg;
        status_next = status_reg;
        rdv_next    = rdv_reg;
        data_next   = data_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_found_next  = m_found_reg;
        m_rdv_next    = m_rdv_reg;
        m_count_next  = m_count_reg;
        we    = 1'b0;
        waddr = idx_reg[AW-1:0];
        wdata = rdata;
        raddr = idx_reg[AW-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    func_next   = s_func;
                    val_next    = s_value;
                    nval_next   = s_new_value;
                    all_next    = s_replace_all;
                    status_next = ST_OK;
                    found_next  = '0;
                    rdv_next    = '0;
                    state_next  = S_DONE;
                    if (s_func <= FN_INS_AT && is_full) begin
                        status_next = ST_FULL;
                    end else if (s_func >= FN_DEL_END && s_func <= FN_READ && is_empty) begin
                        status_next = ST_EMPTY;
                    end else begin
                        case (s_func)
                            FN_APPEND: begin
                                we         = 1'b1;
                                waddr      = count_reg[AW-1:0];
                                wdata      = s_value;
                                count_next = count_reg + CW'(1);
                            end
                            FN_INS_FRONT: begin
                                kidx_next  = '0;
                                idx_next   = count_reg;
                                state_next = S_UP_RD;
                            end
                            FN_INS_AT: begin
                                if (pos_ok) begin
                                    kidx_next  = CW'(pos_x - XW'(1));
                                    idx_next   = count_reg;
                                    state_next = S_UP_RD;
                                end else begin
                                    status_next = ST_BADPOS;
                                end
                            end
                            FN_DEL_END: begin
                                count_next = count_reg - CW'(1);
                            end
                            FN_DEL_AT: begin
                                if (pos_ok) begin
                                    idx_next   = CW'(pos_x - XW'(1));
                                    state_next = S_DN_RD;
                                end else begin
                                    status_next = ST_BADPOS;
                                end
                            end
                            FN_UPDATE, FN_LSEARCH: begin
                                idx_next   = '0;
                                state_next = S_SCAN_RD;
                            end
                            FN_BSEARCH: begin
                                idx_next   = '0;
                                state_next = S_ASC_RD;
                            end
                            FN_SORT: begin
                                idx_next   = '0;
                                n_next     = count_reg;
                                state_next = S_SORT_RD;
                            end
                            FN_READ: begin
                                if (pos_ok) begin
                                    raddr      = AW'(pos_x - XW'(1));
                                    state_next = S_READ_WR;
                                end else begin
                                    status_next = ST_BADPOS;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            // shift entries up from the tail, then drop the new word at kidx
            S_UP_RD: begin
                if (idx_reg == kidx_reg) begin
                    we         = 1'b1;
                    wdata      = val_reg;
                    count_next = count_reg + CW'(1);
                    state_next = S_DONE;
                end else begin
                    raddr      = idx_m1[AW-1:0];
                    state_next = S_UP_WR;
                end
            end
            S_UP_WR: begin
                we         = 1'b1;
                idx_next   = idx_m1;
                state_next = S_UP_RD;
            end
            S_DN_RD: begin
                if (idx_p1 >= count_reg) begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end else begin
                    raddr      = idx_p1[AW-1:0];
                    state_next = S_DN_WR;
                end
            end
            S_DN_WR: begin
                we         = 1'b1;
                idx_next   = idx_p1;
                state_next = S_DN_RD;
            end
            S_SCAN_RD: begin
                if (idx_reg == count_reg) begin
                    if (found_reg == '0) begin
                        status_next = ST_NOTFOUND;
                    end
                    state_next = S_DONE;
                end else begin
                    state_next = S_SCAN_WR;
                end
            end
            S_SCAN_WR: begin
                idx_next   = idx_p1;
                state_next = S_SCAN_RD;
                if (match) begin
                    if (found_reg == '0) begin
                        found_next = idx_p1;
                    end
                    if (func_reg == FN_UPDATE) begin
                        we    = 1'b1;
                        wdata = nval_reg;
                    end
                    if (!(func_reg == FN_UPDATE && all_reg)) begin
                        state_next = S_DONE;
                    end
                end
            end
            S_ASC_RD: begin
                if (idx_reg == count_reg) begin
                    lo_next    = '0;
                    hi_next    = BW'(count_reg) - BW'(1);
                    state_next = S_BIS_RD;
                end else begin
                    state_next = S_ASC_WR;
                end
            end
            S_ASC_WR: begin
                data_next  = rdata;
                idx_next   = idx_p1;
                state_next = S_ASC_RD;
                if (idx_reg != '0 && $signed(rdata) < data_reg) begin
                    status_next = ST_NOTSORTED;
                    state_next  = S_DONE;
                end
            end
            S_BIS_RD: begin
                if (lo_reg > hi_reg) begin
                    status_next = ST_NOTFOUND;
                    state_next  = S_DONE;
                end else begin
                    raddr      = mid_w[AW-1:0];
                    mid_next   = mid_w[AW-1:0];
                    state_next = S_BIS_WR;
                end
            end
            S_BIS_WR: begin
                state_next = S_BIS_RD;
                if (match) begin
                    found_next = CW'(mid_reg) + CW'(1);
                    state_next = S_DONE;
                end else if (key_less) begin
                    hi_next = $signed(BW'(mid_reg)) - BW'(1);
                end else begin
                    lo_next = $signed(BW'(mid_reg)) + BW'(1);
                end
            end
            // one bubble pass carries the running maximum toward the end
            S_SORT_RD: begin
                if (n_reg < CW'(2)) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_SORT_WR;
                end
            end
            S_SORT_WR: begin
                if (idx_reg == '0) begin
                    data_next = rdata;
                end else begin
                    we    = 1'b1;
                    waddr = idx_m1[AW-1:0];
                    if ($signed(rdata) < data_reg) begin
                        wdata = rdata;
                    end else begin
                        wdata     = data_reg;
                        data_next = rdata;
                    end
                end
                if (idx_p1 == n_reg) begin
                    state_next = S_SORT_END;
                end else begin
                    idx_next   = idx_p1;
                    state_next = S_SORT_RD;
                end
            end
            S_SORT_END: begin
                we         = 1'b1;
                waddr      = AW'(n_reg - CW'(1));
                wdata      = data_reg;
                n_next     = n_reg - CW'(1);
                idx_next   = '0;
                state_next = S_SORT_RD;
            end
            S_READ_WR: begin
                rdv_next   = rdata;
                state_next = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_found_next  = fnd_x[POS_W-1:0];
                    m_rdv_next    = rdv_reg;
                    m_count_next  = cnt_x[POS_W-1:0];
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_valid_reg  <= m_valid_next;
            idx_reg      <= idx_next;
            kidx_reg     <= kidx_next;
            n_reg        <= n_next;
            found_reg    <= found_next;
            func_reg     <= func_next;
            val_reg      <= val_next;
            nval_reg     <= nval_next;
            all_reg      <= all_next;
            status_reg   <= status_next;
            rdv_reg      <= rdv_next;
            data_reg     <= data_next;
            lo_reg       <= lo_next;
            hi_reg       <= hi_next;
            mid_reg      <= mid_next;
            m_status_reg <= m_status_next;
            m_found_reg  <= m_found_next;
            m_rdv_reg    <= m_rdv_next;
            m_count_reg  <= m_count_next;
        end
    end
endmodule

/* src/ase_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ase_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

/* verif/array_store_checker.sv */
// Checker for the array store engine: watches both channels, keeps its own copy
// of the array and count, predicts each result word and compares it field by field.
// Depends on ase_pkg.
module array_store_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic [ase_pkg::FUNC_W-1:0]         s_func,
    input  logic [ase_pkg::POS_W-1:0]          s_position,
    input  logic signed [ase_pkg::DATA_W-1:0]  s_value,
    input  logic signed [ase_pkg::DATA_W-1:0]  s_new_value,
    input  logic                               s_replace_all,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic [ase_pkg::STATUS_W-1:0]       m_status,
    input  logic [ase_pkg::POS_W-1:0]          m_found_position,
    input  logic signed [ase_pkg::DATA_W-1:0]  m_read_value,
    input  logic [ase_pkg::POS_W-1:0]          m_count_now,
    output int                                 fail_count,
    output int                                 pending,
    output int                                 last_count
);
    import ase_pkg::*;

    localparam int CAP = CAPACITY_DEF;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [POS_W-1:0]        found;
        logic signed [DATA_W-1:0] rd;
        logic [POS_W-1:0]        count;
    } result_t;

    logic signed [DATA_W-1:0] shadow_words [CAP];
    int                       shadow_count;
    result_t                  expected_results [$];

    function automatic int find_first(logic signed [DATA_W-1:0] key);
        for (int i = 0; i < shadow_count; i++)
            if (shadow_words[i] == key) return i + 1;
        return 0;
    endfunction

    function automatic bit shadow_ascending();
        for (int i = 1; i < shadow_count; i++)
            if (shadow_words[i] < shadow_words[i-1]) return 0;
        return 1;
    endfunction

    function automatic int bisect_key(logic signed [DATA_W-1:0] key);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = shadow_count - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (shadow_words[mid] == key) return mid + 1;
            if (key < shadow_words[mid]) hi = mid - 1;
            else lo = mid + 1;
        end
        return 0;
    endfunction

    function automatic void insert_word(int idx, logic signed [DATA_W-1:0] v);
        for (int j = shadow_count; j > idx; j--) shadow_words[j] = shadow_words[j-1];
        shadow_words[idx] = v;
        shadow_count++;
    endfunction

    function automatic result_t apply_request(logic [FUNC_W-1:0] fn, int pos,
            logic signed [DATA_W-1:0] val, logic signed [DATA_W-1:0] nval, bit all_m);
        result_t r;
        bit pos_ok;
        logic signed [DATA_W-1:0] t;
        r = '0;
        pos_ok = pos >= 1 && pos <= shadow_count;
        if (fn <= FN_INS_AT && shadow_count >= CAP) begin
            r.status = ST_FULL;
        end else if (fn >= FN_DEL_END && fn <= FN_READ && shadow_count == 0) begin
            r.status = ST_EMPTY;
        end else begin
            case (fn)
                FN_APPEND: insert_word(shadow_count, val);
                FN_INS_FRONT: insert_word(0, val);
                FN_INS_AT: begin
                    if (pos_ok) insert_word(pos - 1, val);
                    else r.status = ST_BADPOS;
                end
                FN_DEL_END: shadow_count--;
                FN_DEL_AT: begin
                    if (pos_ok) begin
                        for (int i = pos - 1; i + 1 < shadow_count; i++)
                            shadow_words[i] = shadow_words[i+1];
                        shadow_count--;
                    end else begin
                        r.status = ST_BADPOS;
                    end
                end
                FN_UPDATE: begin
                    r.found = POS_W'(find_first(val));
                    if (r.found == 0) r.status = ST_NOTFOUND;
                    else if (all_m) begin
                        for (int i = 0; i < shadow_count; i++)
                            if (shadow_words[i] == val) shadow_words[i] = nval;
                    end else begin
                        shadow_words[r.found - 1] = nval;
                    end
                end
                FN_LSEARCH: begin
                    r.found = POS_W'(find_first(val));
                    if (r.found == 0) r.status = ST_NOTFOUND;
                end
                FN_BSEARCH: begin
                    if (!shadow_ascending()) r.status = ST_NOTSORTED;
                    else begin
                        r.found = POS_W'(bisect_key(val));
                        if (r.found == 0) r.status = ST_NOTFOUND;
                    end
                end
                FN_SORT: begin
                    for (int i = 0; i + 1 < shadow_count; i++)
                        for (int j = 0; j + 1 < shadow_count - i; j++)
                            if (shadow_words[j+1] < shadow_words[j]) begin
                                t = shadow_words[j];
                                shadow_words[j] = shadow_words[j+1];
                                shadow_words[j+1] = t;
                            end
                end
                FN_READ: begin
                    if (pos_ok) r.rd = shadow_words[pos - 1];
                    else r.status = ST_BADPOS;
                end
                default: ;
            endcase
        end
        r.count = shadow_count[POS_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        result_t got;
        result_t exp_r;
        if (!aresetn) begin
            shadow_count = 0;
            expected_results.delete();
            fail_count <= 0;
        end else begin
            if (s_valid && s_ready)
                expected_results.push_back(apply_request(s_func, s_position, s_value,
                                                         s_new_value, s_replace_all));
            if (m_valid && m_ready) begin
                got = '{m_status, m_found_position, m_read_value, m_count_now};
                if (expected_results.size() == 0) begin
                    $display("%0t: result word with nothing expected: %p", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

    always_comb begin
        pending = expected_results.size();
        last_count = shadow_count;
    end
endmodule

/* verif/testbench.sv */
// Top of the array store engine testbench: clock, reset, request stimulus,
// result-side stalls and the verdict. Depends on ase_pkg, the engine and the checker.
module testbench;
    import ase_pkg::*;

    logic                      aclk = 0;
    logic                      aresetn = 0;
    logic                      s_valid = 0;
    logic                      s_ready;
    logic [FUNC_W-1:0]         s_func = '0;
    logic [POS_W-1:0]          s_position = '0;
    logic signed [DATA_W-1:0]  s_value = '0;
    logic signed [DATA_W-1:0]  s_new_value = '0;
    logic                      s_replace_all = 0;
    logic                      m_valid;
    logic                      m_ready = 0;
    logic [STATUS_W-1:0]       m_status;
    logic [POS_W-1:0]          m_found_position;
    logic signed [DATA_W-1:0]  m_read_value;
    logic [POS_W-1:0]          m_count_now;
    int                        fail_count;
    int                        pending;
    int                        last_count;
    bit                        long_hold = 0;
    logic signed [DATA_W-1:0]  pool [8];

    always #2 aclk = ~aclk;

    array_store_engine dut (.*);
    array_store_checker chk (.*);

    function automatic int short_or_long_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // Send one word and hold it until taken.
    task automatic send_word(logic [FUNC_W-1:0] fn, int pos, logic signed [DATA_W-1:0] v,
                             logic signed [DATA_W-1:0] nv, bit all_m, bit gaps);
        int g;
        s_valid       <= 1;
        s_func        <= fn;
        s_position    <= pos[POS_W-1:0];
        s_value       <= v;
        s_new_value   <= nv;
        s_replace_all <= all_m;
        do @(posedge aclk); while (!s_ready);
        g = gaps ? short_or_long_gap() : 0;
        if (g > 0) begin
            s_valid <= 0;
            repeat (g) @(posedge aclk);
        end
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'sh7fffffff;
            2: return 32'sh80000000;
            default: return pool[$urandom_range(0, 7)];
        endcase
    endfunction

    // Random request biased toward useful operations for the current fill level.
    task automatic random_request(bit gaps);
        logic [FUNC_W-1:0] fn;
        int pos;
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)       fn = FUNC_W'($urandom_range(10, 15));
        else if (r < 34) fn = (last_count < 10) ? FN_APPEND : FN_DEL_AT;
        else             fn = FUNC_W'($urandom_range(0, 9));
        if (fn == FN_SORT && last_count > 8 && $urandom_range(0, 1)) fn = FN_BSEARCH;
        if ($urandom_range(0, 9) == 0) pos = $urandom_range(0, 31);
        else pos = $urandom_range(1, last_count > 0 ? last_count : 1);
        send_word(fn, pos, pick_value(), pick_value(), $urandom_range(0, 1), gaps);
    endtask

    // Drop valid, let the last accept settle, then wait for every result.
    task automatic wait_drained();
        s_valid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Result side: random stalls, with one long hold-off on request.
    initial begin
        int g;
        @(posedge aresetn);
        forever begin
            if (long_hold) begin
                m_ready <= 0;
                repeat (400) @(posedge aclk);
                long_hold = 0;
            end
            g = short_or_long_gap();
            if (g > 0) begin
                m_ready <= 0;
                repeat (g) @(posedge aclk);
            end
            m_ready <= 1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    initial begin
        for (int i = 0; i < 8; i++) pool[i] = $urandom_range(0, 15) - 8;
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // Directed: empty checks, fill to full, bad positions, updates, searches, sort.
        send_word(FN_DEL_END, 1, 0, 0, 0, 0);
        send_word(FN_READ, 1, 0, 0, 0, 0);
        send_word(FN_BSEARCH, 0, 0, 0, 0, 0);
        send_word(FN_APPEND, 0, 32'sh7fffffff, 0, 0, 0);
        send_word(FN_INS_FRONT, 0, 32'sh80000000, 0, 0, 0);
        send_word(FN_INS_AT, 2, -1, 0, 0, 0);
        send_word(FN_INS_AT, 0, 5, 0, 0, 0);
        send_word(FN_INS_AT, 31, 5, 0, 0, 0);
        send_word(FN_BSEARCH, 0, -1, 0, 0, 0);
        for (int i = 0; i < 13; i++) send_word(FN_APPEND, 0, i % 3, 0, 0, 0);
        send_word(FN_APPEND, 0, 9, 0, 0, 0);
        send_word(FN_INS_AT, 1, 9, 0, 0, 0);
        send_word(FN_UPDATE, 0, 1, 32'sh55aa55aa, 1, 0);
        send_word(FN_UPDATE, 0, 2, -7, 0, 0);
        send_word(FN_UPDATE, 0, 12345, 0, 0, 0);
        send_word(FN_LSEARCH, 0, 0, 0, 0, 0);
        send_word(FN_BSEARCH, 0, 0, 0, 0, 0);
        send_word(FN_SORT, 0, 0, 0, 0, 0);
        send_word(FN_BSEARCH, 0, 0, 0, 0, 0);
        send_word(FN_READ, 16, 0, 0, 0, 0);
        send_word(FN_READ, 17, 0, 0, 0, 0);
        send_word(FN_DEL_AT, 16, 0, 0, 0, 0);
        send_word(FN_DEL_AT, 0, 0, 0, 0, 0);
        send_word(4'd15, 0, 0, 0, 0, 0);
        // Sender pause until every result has come.
        wait_drained();
        // Receiver holds off while requests keep coming.
        long_hold = 1;
        for (int i = 0; i < 30; i++) random_request(0);
        for (int i = 0; i < 1700; i++) begin
            if (i % 300 == 299) wait_drained();
            random_request(1);
        end
        wait_drained();
        repeat (700) @(posedge aclk);
        if (fail_count == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #20000000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
